// ----- rtl/hrd_pkg.sv -----
// ----------------------------------------------------------------------------
// hrd_pkg
// Shared types and constants for the H.264 RTP depacketizer: packet type
// codes, Annex B start code bytes and the result-run descriptor.
// ----------------------------------------------------------------------------
`default_nettype none

package hrd_pkg;

  // NAL / RTP payload type codes (low five bits of the indicator)
  localparam logic [4:0] TypeStapA  = 5'd24;
  localparam logic [4:0] TypeStapB  = 5'd25;
  localparam logic [4:0] TypeMtap24 = 5'd27;
  localparam logic [4:0] TypeFuA    = 5'd28;

  // FU header flag bits
  localparam int unsigned FuStartBit = 7;
  localparam int unsigned FuEndBit   = 6;

  // Start code bytes
  localparam logic [7:0] ScZeroByte = 8'h00;
  localparam logic [7:0] ScOneByte  = 8'h01;

  // Result run lengths for one input item, and byte positions within a run
  localparam logic [2:0] RunNone     = 3'd0;
  localparam logic [2:0] RunByte     = 3'd1;
  localparam logic [2:0] RunSc       = 3'd4;
  localparam logic [2:0] RunScByte   = 3'd5;
  localparam logic [2:0] ScLastPos   = 3'd3;
  localparam logic [2:0] DataPos     = 3'd4;

  // Run of results caused by one input item
  typedef struct packed {
    logic [2:0] count;      // number of results
    logic [7:0] data;       // payload byte (single byte or after start code)
    logic       short_unit; // flag the last result as a cut-off unit
  } run_t;

endpackage

`default_nettype wire

// ----- rtl/h264_rtp_depacketizer_top.sv -----
// ----------------------------------------------------------------------------
// h264_rtp_depacketizer_top
// RTP H.264 depacketizer (STAP-A, FU-A, single NAL) to Annex B byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one payload byte per item
//   with pkt_last_i marking the final byte of each RTP packet. Output
//   channel (out_valid_o/out_ready_i) gives one Annex B byte per item, with
//   nal_begin_o on the first start code byte, nal_short_o on the byte that
//   ends a cut-off STAP-A unit and run_last_o on the last byte caused by an
//   input item.
//   The first result of an item is valid the cycle after it is
//   accepted. An item causes 0, 1, 4 or 5 results; the result register
//   plays one out per cycle while the receiver is ready, so the input
//   takes one item per cycle for payload bytes but pauses where a start
//   code goes in. Items with no results are taken without delay.
//   Reset clears the parser (waiting for an indicator byte, no fragment
//   open) and empties the result register.
//   When the receiver stalls, the held result stays put and the input
//   takes no further item until the last result of the held run leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module h264_rtp_depacketizer_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       pkt_last_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            nal_begin_o,
  output logic            nal_short_o,
  output logic            run_last_o
);
  import hrd_pkg::*;

  run_t run;
  logic accept;

  assign accept = in_valid_i && in_ready_o;

  hrd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .pkt_last_i  (pkt_last_i),
    .run_o       (run)
  );

  hrd_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .run_i       (run),
    .free_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .nal_begin_o (nal_begin_o),
    .nal_short_o (nal_short_o),
    .run_last_o  (run_last_o)
  );

endmodule

`default_nettype wire

// ----- rtl/hrd_parser.sv -----
// ----------------------------------------------------------------------------
// hrd_parser
// Packet parser: tracks the packet phase, STAP-A sizes and FU-A fragment
// state, and turns each accepted item into a run descriptor.
// ----------------------------------------------------------------------------
`default_nettype none

module hrd_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        pkt_last_i,
  output hrd_pkg::run_t    run_o
);
  import hrd_pkg::*;

  typedef enum logic [2:0] {
    PhInd,
    PhSizeHi,
    PhSizeLo,
    PhStapData,
    PhFuHdr,
    PhPass,
    PhDrop
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  ind_bits_q, ind_bits_d;
  logic [7:0]  size_hi_q, size_hi_d;
  logic [15:0] bytes_left_q, bytes_left_d;
  logic        frag_open_q, frag_open_d;

  logic [4:0]  nal_type;
  logic [15:0] left_dec;
  run_t        run;

  assign nal_type = data_byte_i[4:0];
  assign left_dec = bytes_left_q - 16'd1;

  // Next state and result run for the item at the input
  always_comb begin
    phase_d        = phase_q;
    ind_bits_d     = ind_bits_q;
    size_hi_d      = size_hi_q;
    bytes_left_d   = bytes_left_q;
    frag_open_d    = frag_open_q;
    run.count      = RunNone;
    run.data       = data_byte_i;
    run.short_unit = 1'b0;

    unique case (phase_q)
      PhInd: begin
        ind_bits_d = data_byte_i[7:5];
        if (nal_type == TypeStapA) begin
          phase_d = PhSizeHi;
        end else if (nal_type == TypeFuA) begin
          phase_d = PhFuHdr;
        end else if (nal_type >= TypeStapB && nal_type <= TypeMtap24) begin
          phase_d = PhDrop;
        end else begin
          run.count = RunScByte;
          phase_d   = PhPass;
        end
      end
      PhSizeHi: begin
        size_hi_d = data_byte_i;
        phase_d   = PhSizeLo;
      end
      PhSizeLo: begin
        if ({size_hi_q, data_byte_i} == 16'd0) begin
          phase_d = PhDrop;
        end else begin
          run.count      = RunSc;
          run.short_unit = pkt_last_i;
          bytes_left_d   = {size_hi_q, data_byte_i};
          phase_d        = PhStapData;
        end
      end
      PhStapData: begin
        run.count    = RunByte;
        bytes_left_d = left_dec;
        if (left_dec == 16'd0) begin
          phase_d = PhSizeHi;
        end else begin
          run.short_unit = pkt_last_i;
        end
      end
      PhFuHdr: begin
        if (data_byte_i[FuStartBit]) begin
          run.count   = RunScByte;
          run.data    = {ind_bits_q, data_byte_i[4:0]};
          frag_open_d = 1'b1;
          phase_d     = PhPass;
        end else if (frag_open_q) begin
          if (data_byte_i[FuEndBit]) frag_open_d = 1'b0;
          phase_d = PhPass;
        end else begin
          phase_d = PhDrop;
        end
      end
      PhPass: begin
        run.count = RunByte;
      end
      PhDrop: begin
        run.count = RunNone;
      end
      default: begin
        phase_d = PhInd;
      end
    endcase

    // packet end always waits for a new indicator
    if (pkt_last_i) phase_d = PhInd;
  end

  assign run_o = run;

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhInd;
      ind_bits_q   <= 3'd0;
      size_hi_q    <= 8'd0;
      bytes_left_q <= 16'd0;
      frag_open_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q      <= phase_d;
      ind_bits_q   <= ind_bits_d;
      size_hi_q    <= size_hi_d;
      bytes_left_q <= bytes_left_d;
      frag_open_q  <= frag_open_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hrd_emitter.sv -----
// ----------------------------------------------------------------------------
// hrd_emitter
// Result register: holds the run of one item and plays it out one byte per
// accepted output, start code first.
// ----------------------------------------------------------------------------
`default_nettype none

module hrd_emitter (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  wire hrd_pkg::run_t run_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               nal_begin_o,
  output logic               nal_short_o,
  output logic               run_last_o
);
  import hrd_pkg::*;

  logic [2:0] count_q, count_d;
  logic [2:0] pos_q, pos_d;
  logic [7:0] data_q;
  logic       short_q;
  logic       at_last;
  logic       out_fire;

  assign out_valid_o = (count_q != RunNone);
  assign at_last     = (pos_q == count_q - 3'd1);
  assign out_fire    = out_valid_o && out_ready_i;
  // free once the run register is empty or its last byte leaves this cycle
  assign free_o      = !out_valid_o || (out_ready_i && at_last);

  // Output byte selection within the run
  always_comb begin
    if (count_q == RunByte || pos_q == DataPos) begin
      out_byte_o = data_q;
    end else if (pos_q == ScLastPos) begin
      out_byte_o = ScOneByte;
    end else begin
      out_byte_o = ScZeroByte;
    end
  end

  assign nal_begin_o = (count_q >= RunSc) && (pos_q == 3'd0);
  assign run_last_o  = at_last;
  assign nal_short_o = short_q && at_last;

  // Run control
  always_comb begin
    count_d = count_q;
    pos_d   = pos_q;
    if (out_fire) begin
      if (at_last) begin
        count_d = RunNone;
      end else begin
        pos_d = pos_q + 3'd1;
      end
    end
    if (load_i && run_i.count != RunNone) begin
      count_d = run_i.count;
      pos_d   = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= RunNone;
      pos_q   <= 3'd0;
    end else begin
      count_q <= count_d;
      pos_q   <= pos_d;
    end
  end

  // Run payload
  always_ff @(posedge clk_i) begin
    if (load_i && run_i.count != RunNone) begin
      data_q  <= run_i.data;
      short_q <= run_i.short_unit;
    end
  end

  // Checks
  a_pos_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pos_q < count_q)
    else $error("run position beyond run length");

  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == RunNone || count_q == RunByte || count_q == RunSc || count_q == RunScByte)
    else $error("illegal run length");

  a_begin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && nal_begin_o) |-> out_byte_o == ScZeroByte)
    else $error("unit start not on a start code byte");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && run_i.count != RunNone) |-> free_o)
    else $error("run loaded over a pending run");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the H.264 RTP depacketizer. A directed table covers
// the packet types and the corner cases: short units, zero sizes, orphan and
// empty fragments, dropped types. Random packet traffic follows: STAP-A,
// FU-A sequences, single NAL units and noise. Every Annex B output byte is
// checked against a cycle-free parser model, or the table's run where set.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hrd_pkg::*;

  localparam int RandItems = 234;
  localparam int MaxShown  = 10;

  // parser phase of the bench model
  typedef enum logic [2:0] {
    PhIndicator, PhSizeHigh, PhSizeLow, PhStapData, PhFuHeader, PhPass, PhDrop
  } parse_phase_e;

  // receiver stall styles
  typedef enum int {RxFree, RxCoin, RxPulse, RxLongStall} rx_mode_e;

  // one output byte as expected on the result port
  typedef struct packed {
    logic [7:0] val;
    logic       nal_begin;
    logic       nal_short;
    logic       run_last;
  } annexb_t;

  // one payload item; want is used only where typed is set
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    run_t       want;
  } stim_t;

  localparam int DirRows = 26;
  localparam stim_t DirTab [DirRows] = '{
    // single NAL units, extremes of the byte
    '{8'h00, 1'b1, 1'b1, '{RunScByte, 8'h00, 1'b0}},
    '{8'hFF, 1'b0, 1'b1, '{RunScByte, 8'hFF, 1'b0}},
    '{8'hAB, 1'b1, 1'b1, '{RunByte,   8'hAB, 1'b0}},
    // STAP-A, size 4, cut off after three bytes
    '{8'h78, 1'b0, 1'b1, '{RunNone,   8'h00, 1'b0}},
    '{8'h00, 1'b0, 1'b1, '{RunNone,   8'h00, 1'b0}},
    '{8'h04, 1'b0, 1'b1, '{RunSc,     8'h00, 1'b0}},
    '{8'hFF, 1'b0, 1'b1, '{RunByte,   8'hFF, 1'b0}},
    '{8'h00, 1'b0, 1'b1, '{RunByte,   8'h00, 1'b0}},
    '{8'h55, 1'b1, 1'b1, '{RunByte,   8'h55, 1'b1}},
    // STAP-A ending right after a size: flag on the start code
    '{8'h18, 1'b0, 1'b1, '{RunNone,   8'h00, 1'b0}},
    '{8'h00, 1'b0, 1'b1, '{RunNone,   8'h00, 1'b0}},
    '{8'h05, 1'b1, 1'b1, '{RunSc,     8'h00, 1'b1}},
    // STAP-A with a zero size drops the rest
    '{8'h18, 1'b0, 1'b1, '{RunNone,   8'h00, 1'b0}},
    '{8'h00, 1'b0, 1'b1, '{RunNone,   8'h00, 1'b0}},
    '{8'h00, 1'b0, 1'b1, '{RunNone,   8'h00, 1'b0}},
    '{8'h12, 1'b1, 1'b1, '{RunNone,   8'h00, 1'b0}},
    // STAP-B dropped
    '{8'h19, 1'b0, 1'b1, '{RunNone,   8'h00, 1'b0}},
    '{8'h44, 1'b1, 1'b1, '{RunNone,   8'h00, 1'b0}},
    // empty FU-A, then an orphan fragment
    '{8'hFC, 1'b1, 1'b1, '{RunNone,   8'h00, 1'b0}},
    '{8'h7C, 1'b0, 1'b1, '{RunNone,   8'h00, 1'b0}},
    '{8'h05, 1'b1, 1'b1, '{RunNone,   8'h00, 1'b0}},
    // FU-A start with S and E, then a new start while open
    '{8'h7C, 1'b0, 1'b0, '{RunNone,   8'h00, 1'b0}},
    '{8'hC5, 1'b0, 1'b0, '{RunNone,   8'h00, 1'b0}},
    '{8'h99, 1'b1, 1'b0, '{RunNone,   8'h00, 1'b0}},
    '{8'h7C, 1'b0, 1'b0, '{RunNone,   8'h00, 1'b0}},
    '{8'h86, 1'b1, 1'b0, '{RunNone,   8'h00, 1'b0}}
  };

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] data_byte_i = 8'h00;
  logic       pkt_last_i  = 1'b0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       nal_begin_o;
  logic       nal_short_o;
  logic       run_last_o;

  // bench copy of the parser state
  parse_phase_e prs_phase     = PhIndicator;
  logic [2:0]   prs_fnri      = '0;
  logic [7:0]   prs_size_hi   = '0;
  logic [15:0]  prs_left      = '0;
  logic         prs_frag_open = 1'b0;

  annexb_t    annexb_q[$];
  stim_t      stim_q[$];
  logic [7:0] pkt_buf[$];

  int err_cnt     = 0;
  int items_in    = 0;
  int bytes_out   = 0;
  int useful_cnt  = 0;
  int burst_left  = 0;
  int n_stap      = 0;
  int n_fu        = 0;
  int n_single    = 0;
  int n_other     = 0;

  h264_rtp_depacketizer_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .pkt_last_i  (pkt_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .nal_begin_o (nal_begin_o),
    .nal_short_o (nal_short_o),
    .run_last_o  (run_last_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Parser model: advances the state by one payload byte, returns the run
  function automatic run_t parse_byte(input logic [7:0] b, input logic l);
    run_t        r;
    logic [4:0]  ptype;
    logic [15:0] size;
    r = '{count: RunNone, data: b, short_unit: 1'b0};
    case (prs_phase)
      PhIndicator: begin
        ptype    = b[4:0];
        prs_fnri = b[7:5];
        if (ptype == TypeStapA) begin
          prs_phase = PhSizeHigh;
        end else if (ptype == TypeFuA) begin
          prs_phase = PhFuHeader;
        end else if (ptype >= TypeStapB && ptype <= TypeMtap24) begin
          prs_phase = PhDrop;
        end else begin
          r.count   = RunScByte;
          prs_phase = PhPass;
        end
      end
      PhSizeHigh: begin
        prs_size_hi = b;
        prs_phase   = PhSizeLow;
      end
      PhSizeLow: begin
        size = {prs_size_hi, b};
        if (size == 16'd0) begin
          prs_phase = PhDrop;
        end else begin
          r.count      = RunSc;
          r.short_unit = l;
          prs_left     = size;
          prs_phase    = PhStapData;
        end
      end
      PhStapData: begin
        r.count  = RunByte;
        prs_left = prs_left - 16'd1;
        if (prs_left == 16'd0) prs_phase = PhSizeHigh;
        else r.short_unit = l;
      end
      PhFuHeader: begin
        if (b[FuStartBit]) begin
          // rebuilt NAL header: F and NRI from the indicator, type from the FU header
          r.count       = RunScByte;
          r.data        = {prs_fnri, b[4:0]};
          prs_frag_open = 1'b1;
          prs_phase     = PhPass;
        end else if (prs_frag_open) begin
          if (b[FuEndBit]) prs_frag_open = 1'b0;
          prs_phase = PhPass;
        end else begin
          prs_phase = PhDrop;
        end
      end
      PhPass: r.count = RunByte;
      default: ;
    endcase
    if (l) prs_phase = PhIndicator;
    return r;
  endfunction

  // expand a run into output bytes and append them to the pending list
  function automatic void queue_run(input run_t r);
    annexb_t run_q[$];
    annexb_t e;
    if (r.count == RunSc || r.count == RunScByte) begin
      run_q.push_back('{ScZeroByte, 1'b1, 1'b0, 1'b0});
      run_q.push_back('{ScZeroByte, 1'b0, 1'b0, 1'b0});
      run_q.push_back('{ScZeroByte, 1'b0, 1'b0, 1'b0});
      run_q.push_back('{ScOneByte,  1'b0, 1'b0, 1'b0});
    end
    if (r.count == RunByte || r.count == RunScByte)
      run_q.push_back('{r.data, 1'b0, 1'b0, 1'b0});
    if (run_q.size() != 0) begin
      e           = run_q.pop_back();
      e.run_last  = 1'b1;
      e.nal_short = r.short_unit;
      run_q.push_back(e);
    end
    foreach (run_q[k]) annexb_q.push_back(run_q[k]);
  endfunction

  // move the packet buffer into the stimulus list, last byte marked
  function automatic void flush_packet();
    foreach (pkt_buf[k])
      stim_q.push_back('{pkt_buf[k], k == pkt_buf.size() - 1, 1'b0, '0});
    useful_cnt += pkt_buf.size();
    pkt_buf.delete();
  endfunction

  // single NAL unit packet of any pass-through type
  function automatic void gen_single();
    logic [4:0] ptype;
    do ptype = 5'($urandom_range(0, 31));
    while (ptype >= TypeStapA && ptype <= TypeFuA);
    pkt_buf.push_back({3'($urandom_range(0, 7)), ptype});
    repeat ($urandom_range(0, 5)) pkt_buf.push_back(8'($urandom_range(0, 255)));
    flush_packet();
    n_single++;
  endfunction

  // random packet traffic, mostly well-formed
  function automatic void gen_traffic();
    int         kind, n_frag, sz, cut;
    bit         lose_start;
    logic [2:0] fnri;
    logic [4:0] ftype;
    logic [7:0] hdr;
    while (useful_cnt < RandItems) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        // STAP-A: a few small units, sometimes oversized, zero-terminated or cut
        pkt_buf.push_back({3'($urandom_range(0, 7)), TypeStapA});
        repeat ($urandom_range(1, 3)) begin
          sz = $urandom_range(1, 6);
          if ($urandom_range(0, 9) == 0) begin
            pkt_buf.push_back(8'($urandom_range(1, 255)));
            pkt_buf.push_back(8'($urandom_range(0, 255)));
          end else begin
            pkt_buf.push_back(8'h00);
            pkt_buf.push_back(8'(sz));
          end
          repeat (sz) pkt_buf.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 5) == 0) begin
          pkt_buf.push_back(8'h00);
          pkt_buf.push_back(8'h00);
          repeat ($urandom_range(0, 3)) pkt_buf.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 4) == 0) begin
          cut = $urandom_range(1, pkt_buf.size());
          while (pkt_buf.size() > cut) void'(pkt_buf.pop_back());
        end
        flush_packet();
        n_stap++;
      end else if (kind < 60) begin
        // FU-A sequence; the start is sometimes lost, single units may interleave
        fnri       = 3'($urandom_range(0, 7));
        ftype      = 5'($urandom_range(0, 31));
        n_frag     = $urandom_range(2, 4);
        lose_start = ($urandom_range(0, 9) == 0);
        for (int f = 0; f < n_frag; f++) begin
          if (!(f == 0 && lose_start)) begin
            pkt_buf.push_back({fnri, TypeFuA});
            if ($urandom_range(0, 15) != 0) begin
              hdr             = 8'($urandom_range(0, 255));
              hdr[FuStartBit] = (f == 0);
              hdr[FuEndBit]   = (f == n_frag - 1) || (f == 0 && $urandom_range(0, 7) == 0);
              hdr[4:0]        = ftype;
              pkt_buf.push_back(hdr);
              repeat ($urandom_range(0, 4)) pkt_buf.push_back(8'($urandom_range(0, 255)));
            end
            flush_packet();
            n_fu++;
          end
          if ($urandom_range(0, 4) == 0) gen_single();
        end
      end else if (kind < 80) begin
        gen_single();
      end else if (kind < 90) begin
        // STAP-B / MTAP, dropped whole
        pkt_buf.push_back({3'($urandom_range(0, 7)),
                           5'($urandom_range(TypeStapB, TypeMtap24))});
        repeat ($urandom_range(0, 4)) pkt_buf.push_back(8'($urandom_range(0, 255)));
        flush_packet();
        n_other++;
      end else begin
        // noise packet
        repeat ($urandom_range(1, 6)) pkt_buf.push_back(8'($urandom_range(0, 255)));
        flush_packet();
        n_other++;
      end
    end
  endfunction

  // Sender: bursts of items with random gaps; expectations queued on accept
  task automatic send(input stim_t s);
    run_t pred;
    int   gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 5);
        repeat (gap) begin
          @(negedge clk_i);
          in_valid_i <= 1'b0;
        end
      end
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    data_byte_i <= s.data;
    pkt_last_i  <= s.last;
    do @(posedge clk_i); while (!in_ready_o);
    pred = parse_byte(s.data, s.last);
    queue_run(s.typed ? s.want : pred);
    items_in++;
    burst_left--;
  endtask

  // Receiver: switches between random stall styles
  initial begin : rx_stall
    rx_mode_e mode;
    int       span, hold, cyc;
    hold = 0;
    cyc  = 0;
    @(posedge rst_ni);
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(20, 80);
      repeat (span) begin
        @(negedge clk_i);
        cyc++;
        case (mode)
          RxFree:  out_ready_i <= 1'b1;
          RxCoin:  out_ready_i <= 1'($urandom_range(0, 1));
          RxPulse: out_ready_i <= (cyc % 3 == 0);
          default: begin
            if (hold > 0) begin
              hold--;
              out_ready_i <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
              hold = $urandom_range(3, 15);
              out_ready_i <= 1'b0;
            end else begin
              out_ready_i <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Output check against the oldest pending byte
  always @(posedge clk_i) begin : check_out
    annexb_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      bytes_out++;
      if (annexb_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MaxShown)
          $display("%0t: unexpected output byte %02h, nothing pending", $realtime, out_byte_o);
      end else begin
        want = annexb_q.pop_front();
        if (want.val !== out_byte_o || want.nal_begin !== nal_begin_o ||
            want.nal_short !== nal_short_o || want.run_last !== run_last_o) begin
          err_cnt++;
          if (err_cnt <= MaxShown)
            $display("%0t: byte %0d: expected %02h begin %b short %b last %b, got %02h %b %b %b",
                     $realtime, bytes_out, want.val, want.nal_begin, want.nal_short,
                     want.run_last, out_byte_o, nal_begin_o, nal_short_o, run_last_o);
        end
      end
    end
  end

  // Main sequence
  initial begin : main
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DirRows; i++) send(DirTab[i]);

    gen_traffic();
    foreach (stim_q[i]) send(stim_q[i]);
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (annexb_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d payload bytes (%0d from the directed table), checked %0d output bytes.",
             items_in, DirRows, bytes_out);
    $display("Packets: %0d STAP-A, %0d FU-A, %0d single NAL, %0d dropped or noise.",
             n_stap, n_fu, n_single, n_other);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #2_000_000;
    $display("Timeout with %0d output bytes still pending", annexb_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/hrd_pkg.sv
rtl/hrd_parser.sv
rtl/hrd_emitter.sv
rtl/h264_rtp_depacketizer_top.sv
tb/tb_top.sv
